>>> rtl/core/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

   // register widths
   localparam int unsigned PhaseWidth = 10;
   localparam int unsigned StepWidth  = 4;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CsrIdxWidth = 2;

   // reset values of the phase registers
   localparam logic [PhaseWidth-1:0] WRITE_PHASE_RESET = 10'd5;
   localparam logic [PhaseWidth-1:0] READ_PHASE_RESET  = 10'd10;

   // bits per byte transfer
   localparam logic [CountWidth-1:0] BITS_PER_BYTE = 4'd8;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_WRITE_PHASE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_READ_PHASE  = 2'd1;

   // sequence step codes, reused by every command
   localparam logic [StepWidth-1:0] STEP_0 = 4'd0;
   localparam logic [StepWidth-1:0] STEP_1 = 4'd1;
   localparam logic [StepWidth-1:0] STEP_2 = 4'd2;
   localparam logic [StepWidth-1:0] STEP_3 = 4'd3;
   localparam logic [StepWidth-1:0] STEP_4 = 4'd4;
   localparam logic [StepWidth-1:0] STEP_5 = 4'd5;
   localparam logic [StepWidth-1:0] STEP_6 = 4'd6;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                 cmd_valid;
      logic [1:0]           mode;
      logic [ByteWidth-1:0] data_byte;
      logic                 ack_to_send;
      logic                 sda_in;
   } req_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_release;
      logic                 busy_res;
      logic                 done_res;
      logic [ByteWidth-1:0] read_byte;
      logic                 ack_received;
   } rsp_type;

   // sequencer state
   typedef struct packed {
      cmd_type               cmd;
      logic [StepWidth-1:0]  step;
      logic [CountWidth-1:0] bit_count;
      logic [ByteWidth-1:0]  shift_byte;
      logic [PhaseWidth-1:0] wait_count;
      logic                  scl;
      logic                  sda;
      logic                  busy;
      logic                  ack;
      logic [ByteWidth-1:0]  rx_byte;
      logic                  ack_send;
   } seq_state_type;

endpackage

`default_nettype wire

>>> rtl/core/i2cm_step.sv
`default_nettype none

// One sequence step: acts on the lines and picks the next step and wait.
module i2cm_step (
   input  var i2cm_pkg::seq_state_type       cur,
   input  var logic [i2cm_pkg::PhaseWidth-1:0] write_phase,
   input  var logic [i2cm_pkg::PhaseWidth-1:0] read_phase,
   input  var logic                          sda_in,
   output i2cm_pkg::seq_state_type           nxt,
   output logic                              finish
);

   logic [i2cm_pkg::PhaseWidth-1:0] w_len;
   logic [i2cm_pkg::PhaseWidth-1:0] r_len;
   logic [i2cm_pkg::CountWidth-1:0] bc_inc;

   // zero phase acts as one
   assign w_len  = (write_phase == '0) ? i2cm_pkg::PhaseWidth'(1) : write_phase;
   assign r_len  = (read_phase == '0) ? i2cm_pkg::PhaseWidth'(1) : read_phase;
   assign bc_inc = cur.bit_count + i2cm_pkg::CountWidth'(1);

   always_comb begin
      nxt        = cur;
      nxt.wait_count = '0;
      finish     = 1'b0;
      unique case (cur.cmd)
         i2cm_pkg::CMD_START: begin
            unique case (cur.step)
               i2cm_pkg::STEP_0: begin
                  nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_1;
               end
               i2cm_pkg::STEP_1: begin
                  nxt.scl = 1'b1; nxt.sda = 1'b1;
                  nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_2;
               end
               i2cm_pkg::STEP_2: begin
                  nxt.sda = 1'b0; nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_3;
               end
               i2cm_pkg::STEP_3: begin
                  nxt.scl = 1'b0; finish = 1'b1;
               end
               default: finish = 1'b1;
            endcase
         end
         i2cm_pkg::CMD_STOP: begin
            unique case (cur.step)
               i2cm_pkg::STEP_0: begin
                  nxt.sda = 1'b0; nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_1;
               end
               i2cm_pkg::STEP_1: begin
                  nxt.scl = 1'b1; nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_2;
               end
               i2cm_pkg::STEP_2: begin
                  nxt.sda = 1'b1; nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_3;
               end
               default: finish = 1'b1;
            endcase
         end
         i2cm_pkg::CMD_WRITE: begin
            unique case (cur.step)
               // data bit out, MSB first
               i2cm_pkg::STEP_0: begin
                  nxt.sda = cur.shift_byte[i2cm_pkg::ByteWidth-1];
                  nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_1;
               end
               i2cm_pkg::STEP_1: begin
                  nxt.scl = 1'b1; nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_2;
               end
               i2cm_pkg::STEP_2: begin
                  nxt.scl = 1'b0;
                  nxt.shift_byte = {cur.shift_byte[i2cm_pkg::ByteWidth-2:0], 1'b0};
                  nxt.bit_count = bc_inc;
                  nxt.step = (bc_inc < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::STEP_0
                                                                : i2cm_pkg::STEP_3;
               end
               // acknowledge clock
               i2cm_pkg::STEP_3: begin
                  nxt.sda = 1'b1; nxt.wait_count = w_len; nxt.step = i2cm_pkg::STEP_4;
               end
               i2cm_pkg::STEP_4: begin
                  nxt.scl = 1'b1; nxt.step = i2cm_pkg::STEP_5;
               end
               i2cm_pkg::STEP_5: begin
                  nxt.ack = sda_in;
                  nxt.wait_count = w_len - i2cm_pkg::PhaseWidth'(1);
                  nxt.step = i2cm_pkg::STEP_6;
               end
               i2cm_pkg::STEP_6: begin
                  nxt.scl = 1'b0; finish = 1'b1;
               end
               default: finish = 1'b1;
            endcase
         end
         i2cm_pkg::CMD_READ: begin
            unique case (cur.step)
               i2cm_pkg::STEP_0: begin
                  nxt.sda = 1'b1; nxt.wait_count = r_len; nxt.step = i2cm_pkg::STEP_1;
               end
               i2cm_pkg::STEP_1: begin
                  nxt.scl = 1'b1; nxt.step = i2cm_pkg::STEP_2;
               end
               // sample one tick after the rise
               i2cm_pkg::STEP_2: begin
                  nxt.shift_byte = {cur.shift_byte[i2cm_pkg::ByteWidth-2:0], sda_in};
                  nxt.wait_count = r_len - i2cm_pkg::PhaseWidth'(1);
                  nxt.step = i2cm_pkg::STEP_3;
               end
               i2cm_pkg::STEP_3: begin
                  nxt.scl = 1'b0;
                  nxt.bit_count = bc_inc;
                  nxt.wait_count = r_len;
                  nxt.step = (bc_inc < i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::STEP_1
                                                                : i2cm_pkg::STEP_4;
               end
               i2cm_pkg::STEP_4: begin
                  nxt.sda = cur.ack_send; nxt.wait_count = r_len; nxt.step = i2cm_pkg::STEP_5;
               end
               i2cm_pkg::STEP_5: begin
                  nxt.scl = 1'b1; nxt.wait_count = r_len; nxt.step = i2cm_pkg::STEP_6;
               end
               i2cm_pkg::STEP_6: begin
                  nxt.scl = 1'b0; nxt.rx_byte = cur.shift_byte; finish = 1'b1;
               end
               default: finish = 1'b1;
            endcase
         end
         default: finish = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/i2c_master_byte_engine.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   i2cm_pkg::req_type (one time tick)
// rsp_      out        rsp_valid/rsp_stall   i2cm_pkg::rsp_type (line levels, status)
// csr_      in         csr_we                csr_index, csr_wdata
//
// Every accepted tick yields one response in the next cycle; a tick every cycle
// unless a held response stalls the request side. The sequencer step logic sits
// between the state/config registers and the response register.
// Reset (synchronous) puts SCL and SDA high, idle, phases 5 and 10 ticks.
// A held response stalls the request side; nothing else does.
module i2c_master_byte_engine (
   input  var logic                            clock,
   input  var logic                            reset,
   input  var logic                            req_valid,
   output logic                                req_stall,
   input  var i2cm_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  var logic                            rsp_stall,
   output i2cm_pkg::rsp_type                   rsp_data,
   input  var logic                            csr_we,
   input  var logic [i2cm_pkg::CsrIdxWidth-1:0] csr_index,
   input  var logic [i2cm_pkg::PhaseWidth-1:0] csr_wdata
);

   logic [i2cm_pkg::PhaseWidth-1:0] write_phase_ff;
   logic [i2cm_pkg::PhaseWidth-1:0] read_phase_ff;
   i2cm_pkg::seq_state_type         state_ff;
   i2cm_pkg::seq_state_type         state_in;
   i2cm_pkg::seq_state_type         pre_state;
   i2cm_pkg::seq_state_type         step_state;
   logic                            step_finish;
   logic                            run_step;
   logic                            done;
   logic                            accept;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   i2cm_pkg::rsp_type               rsp_data_ff;
   i2cm_pkg::rsp_type               rsp_data_in;

   // response register frees up when taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         write_phase_ff <= i2cm_pkg::WRITE_PHASE_RESET;
         read_phase_ff  <= i2cm_pkg::READ_PHASE_RESET;
      end else if (csr_we) begin
         if (csr_index == i2cm_pkg::CSR_WRITE_PHASE) write_phase_ff <= csr_wdata;
         if (csr_index == i2cm_pkg::CSR_READ_PHASE)  read_phase_ff  <= csr_wdata;
      end
   end

   // idle: load a new command before its first step
   always_comb begin
      pre_state = state_ff;
      if (!state_ff.busy) begin
         pre_state.cmd       = i2cm_pkg::cmd_type'(req_data.mode);
         pre_state.step      = i2cm_pkg::STEP_0;
         pre_state.bit_count = '0;
         pre_state.busy      = 1'b1;
         if (i2cm_pkg::cmd_type'(req_data.mode) == i2cm_pkg::CMD_WRITE) begin
            pre_state.shift_byte = req_data.data_byte;
         end else if (i2cm_pkg::cmd_type'(req_data.mode) == i2cm_pkg::CMD_READ) begin
            pre_state.shift_byte = '0;
            pre_state.ack_send   = req_data.ack_to_send;
         end
      end
   end

   assign run_step = state_ff.busy ? (state_ff.wait_count == '0) : req_data.cmd_valid;

   i2cm_step u_step (
      .cur         (pre_state),
      .write_phase (write_phase_ff),
      .read_phase  (read_phase_ff),
      .sda_in      (req_data.sda_in),
      .nxt         (step_state),
      .finish      (step_finish)
   );

   // next state for this tick
   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      if (run_step) begin
         state_in = step_state;
         if (step_finish) begin
            state_in.busy = 1'b0;
            done          = 1'b1;
         end
      end else if (state_ff.busy) begin
         state_in.wait_count = state_ff.wait_count - i2cm_pkg::PhaseWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{cmd: i2cm_pkg::CMD_START, step: i2cm_pkg::STEP_0,
                       bit_count: '0, shift_byte: '0, wait_count: '0,
                       scl: 1'b1, sda: 1'b1, busy: 1'b0, ack: 1'b0,
                       rx_byte: '0, ack_send: 1'b0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_comb begin
      rsp_data_in.scl_level    = state_in.scl;
      rsp_data_in.sda_release  = state_in.sda;
      rsp_data_in.busy_res     = state_in.busy;
      rsp_data_in.done_res     = done;
      rsp_data_in.read_byte    = state_in.rx_byte;
      rsp_data_in.ack_received = state_in.ack;
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
   input  var logic              clock,
   input  var logic              reset,
   input  var logic              req_valid,
   input  var logic              req_stall,
   input  var logic              rsp_valid,
   input  var logic              rsp_stall,
   input  var i2cm_pkg::rsp_type rsp_data
);

   // a held response stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held response changed");

   // every accepted tick gives a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted tick without response");

   // finishing tick reports idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.busy_res)
      else $error("done while busy");

   // request side only stalls behind a stalled response
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("stall without backpressure");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
   import i2cm_pkg::*;

   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned TICKS_PER_PHASE = 170;
   localparam int unsigned PHASE_COUNT     = 6;
   localparam int unsigned PRESSURE_PHASE  = 4;

   // indexes past the register list, writes there must change nothing
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE_B = 2'd3;

   typedef enum {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_type;

   // expected line levels and status, one entry per accepted tick
   class bus_level_tracker;
      logic [PhaseWidth-1:0] write_ticks;
      logic [PhaseWidth-1:0] read_ticks;
      cmd_type               cmd;
      logic [StepWidth-1:0]  step;
      logic [CountWidth-1:0] bit_cnt;
      logic [ByteWidth-1:0]  shreg;
      logic [ByteWidth-1:0]  rx_byte;
      logic [PhaseWidth-1:0] wait_cnt;
      logic                  scl;
      logic                  sda;
      logic                  busy;
      logic                  ack;
      logic                  ack_send;
      rsp_type               expected_levels[$];
      int unsigned           errors;

      function new();
         write_ticks = WRITE_PHASE_RESET;
         read_ticks  = READ_PHASE_RESET;
         cmd         = CMD_START;
         step        = STEP_0;
         bit_cnt     = '0;
         shreg       = '0;
         rx_byte     = '0;
         wait_cnt    = '0;
         scl         = 1'b1;
         sda         = 1'b1;
         busy        = 1'b0;
         ack         = 1'b0;
         ack_send    = 1'b0;
         errors      = 0;
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [PhaseWidth-1:0] val);
         if (idx == CSR_WRITE_PHASE) write_ticks = val;
         else if (idx == CSR_READ_PHASE) read_ticks = val;
      endfunction

      function int unsigned pending();
         return expected_levels.size();
      endfunction

      // one sequencer step; returns 1 when the command is complete
      function bit advance_sequence(logic sda_in);
         logic [PhaseWidth-1:0] w;
         logic [PhaseWidth-1:0] r;
         w = write_ticks;
         r = read_ticks;
         if (w == '0) w = PhaseWidth'(1);
         if (r == '0) r = PhaseWidth'(1);
         wait_cnt = '0;
         case (cmd)
            CMD_START: begin
               case (step)
                  STEP_0: begin wait_cnt = w; step = STEP_1; end
                  STEP_1: begin scl = 1'b1; sda = 1'b1; wait_cnt = w; step = STEP_2; end
                  STEP_2: begin sda = 1'b0; wait_cnt = w; step = STEP_3; end
                  STEP_3: begin scl = 1'b0; return 1'b1; end
                  default: return 1'b1;
               endcase
            end
            CMD_STOP: begin
               case (step)
                  STEP_0: begin sda = 1'b0; wait_cnt = w; step = STEP_1; end
                  STEP_1: begin scl = 1'b1; wait_cnt = w; step = STEP_2; end
                  STEP_2: begin sda = 1'b1; wait_cnt = w; step = STEP_3; end
                  default: return 1'b1;
               endcase
            end
            CMD_WRITE: begin
               case (step)
                  STEP_0: begin sda = shreg[ByteWidth-1]; wait_cnt = w; step = STEP_1; end
                  STEP_1: begin scl = 1'b1; wait_cnt = w; step = STEP_2; end
                  STEP_2: begin
                     scl     = 1'b0;
                     shreg   = shreg << 1;
                     bit_cnt = bit_cnt + CountWidth'(1);
                     step    = (bit_cnt < BITS_PER_BYTE) ? STEP_0 : STEP_3;
                  end
                  STEP_3: begin sda = 1'b1; wait_cnt = w; step = STEP_4; end
                  STEP_4: begin scl = 1'b1; step = STEP_5; end
                  STEP_5: begin
                     ack      = sda_in;
                     wait_cnt = w - PhaseWidth'(1);
                     step     = STEP_6;
                  end
                  STEP_6: begin scl = 1'b0; return 1'b1; end
                  default: return 1'b1;
               endcase
            end
            default: begin
               case (step)
                  STEP_0: begin sda = 1'b1; wait_cnt = r; step = STEP_1; end
                  STEP_1: begin scl = 1'b1; step = STEP_2; end
                  STEP_2: begin
                     shreg    = {shreg[ByteWidth-2:0], sda_in};
                     wait_cnt = r - PhaseWidth'(1);
                     step     = STEP_3;
                  end
                  STEP_3: begin
                     scl      = 1'b0;
                     bit_cnt  = bit_cnt + CountWidth'(1);
                     wait_cnt = r;
                     step     = (bit_cnt < BITS_PER_BYTE) ? STEP_1 : STEP_4;
                  end
                  STEP_4: begin sda = ack_send; wait_cnt = r; step = STEP_5; end
                  STEP_5: begin scl = 1'b1; wait_cnt = r; step = STEP_6; end
                  STEP_6: begin scl = 1'b0; rx_byte = shreg; return 1'b1; end
                  default: return 1'b1;
               endcase
            end
         endcase
         return 1'b0;
      endfunction

      // accepted request transaction: advance one tick and queue the expected levels
      function void take_tick(req_type t);
         rsp_type want;
         logic    done;
         done = 1'b0;
         if (busy) begin
            if (wait_cnt != '0) wait_cnt = wait_cnt - PhaseWidth'(1);
            else if (advance_sequence(t.sda_in)) begin
               busy = 1'b0;
               done = 1'b1;
            end
         end else if (t.cmd_valid) begin
            cmd     = cmd_type'(t.mode);
            step    = STEP_0;
            bit_cnt = '0;
            if (cmd == CMD_WRITE) shreg = t.data_byte;
            else if (cmd == CMD_READ) begin
               shreg    = '0;
               ack_send = t.ack_to_send;
            end
            busy = 1'b1;
            if (advance_sequence(t.sda_in)) begin
               busy = 1'b0;
               done = 1'b1;
            end
         end
         want.scl_level    = scl;
         want.sda_release  = sda;
         want.busy_res     = busy;
         want.done_res     = done;
         want.read_byte    = rx_byte;
         want.ack_received = ack;
         expected_levels.push_back(want);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      // accepted response transaction against the oldest expectation
      function void check_levels(rsp_type got);
         rsp_type want;
         if (expected_levels.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected nothing, got %h", $time, got);
            return;
         end
         want = expected_levels.pop_front();
         compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
         compare_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
         compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("ack_received", 8'(want.ack_received), 8'(got.ack_received));
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [PhaseWidth-1:0]  csr_wdata = '0;

   bus_level_tracker levels;
   int unsigned      gap_pct      = 0;
   int unsigned      stall_pct    = 0;
   int unsigned      quiet_cycles = 0;
   bit               bus_open     = 1'b0;

   int unsigned           gap_tab[PHASE_COUNT]   = '{0, 81, 0, 15, 0, 15};
   int unsigned           stall_tab[PHASE_COUNT] = '{0, 0, 81, 15, 0, 15};
   logic [PhaseWidth-1:0] wr_tab[PHASE_COUNT]    = '{10'd1, 10'd2, 10'd3,
                                                     10'd1, 10'd4, 10'd2};
   logic [PhaseWidth-1:0] rd_tab[PHASE_COUNT]    = '{10'd1, 10'd3, 10'd1,
                                                     10'd2, 10'd2, 10'd1};

   i2c_master_byte_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: check accepted transactions, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) levels.check_levels(rsp_data);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic sda_level(sda_mode_type how);
      case (how)
         SDA_LOW:  return 1'b0;
         SDA_HIGH: return 1'b1;
         default:  return 1'($urandom);
      endcase
   endfunction

   // random tick: mostly start / byte transfers / stop, some stray commands
   function automatic req_type random_tick();
      req_type t;
      int      pick;
      t.cmd_valid   = 1'($urandom);
      t.mode        = 2'($urandom);
      t.data_byte   = 8'($urandom);
      t.ack_to_send = 1'($urandom);
      t.sda_in      = 1'($urandom);
      if (!levels.busy) begin
         pick        = $urandom_range(99);
         t.cmd_valid = (pick >= 8);
         if (!bus_open) begin
            if (pick < 85) t.mode = CMD_START;
         end else if (pick < 45) t.mode = CMD_WRITE;
         else if (pick < 80) t.mode = CMD_READ;
         else if (pick < 92) t.mode = CMD_STOP;
         else t.mode = CMD_START;
         if (t.cmd_valid) bus_open = (t.mode != CMD_STOP);
      end
      return t;
   endfunction

   // one request transaction, with random idle cycles ahead of it
   task automatic send_tick(req_type t);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      levels.take_tick(t);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (levels.pending() != 0) @(posedge clock);
   endtask

   task automatic cfg_write(logic [CsrIdxWidth-1:0] idx, logic [PhaseWidth-1:0] val);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      levels.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // issue one command from idle and tick until it completes
   task automatic run_command(cmd_type op, logic [7:0] byte_out, logic ack_bit,
                              sda_mode_type sda_how);
      req_type t;
      t.cmd_valid   = 1'b1;
      t.mode        = op;
      t.data_byte   = byte_out;
      t.ack_to_send = ack_bit;
      t.sda_in      = sda_level(sda_how);
      send_tick(t);
      // commands offered while busy must be ignored
      while (levels.busy) begin
         t.cmd_valid   = 1'($urandom);
         t.mode        = 2'($urandom);
         t.data_byte   = 8'($urandom);
         t.ack_to_send = 1'($urandom);
         t.sda_in      = sda_level(sda_how);
         send_tick(t);
      end
   endtask

   initial begin
      levels = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset phase lengths; all-zero and all-one bytes, ack and nack both ways
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(CMD_WRITE, 8'h00, 1'b1, SDA_LOW);
      run_command(CMD_WRITE, 8'hFF, 1'b0, SDA_HIGH);
      run_command(CMD_READ, 8'h00, 1'b0, SDA_HIGH);
      run_command(CMD_READ, 8'hFF, 1'b1, SDA_LOW);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      send_tick(req_type'(0));

      // zero phase registers behave as one; unmapped indexes are ignored
      cfg_write(CSR_WRITE_PHASE, '0);
      cfg_write(CSR_READ_PHASE, '0);
      cfg_write(CSR_SPARE_A, 10'($urandom));
      cfg_write(CSR_SPARE_B, 10'($urandom));
      run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      run_command(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);
      run_command(CMD_READ, 8'h00, 1'b1, SDA_RANDOM);
      run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);

      // random traffic; register writes may land in the middle of a command
      for (int p = 0; p < PHASE_COUNT; p++) begin
         cfg_write(CSR_WRITE_PHASE, wr_tab[p]);
         cfg_write(CSR_READ_PHASE, rd_tab[p]);
         gap_pct   = gap_tab[p];
         stall_pct = stall_tab[p];
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (p == PRESSURE_PHASE && n == TICKS_PER_PHASE / 2) drain_results();
            send_tick(random_tick());
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (levels.errors == 0 && levels.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

`default_nettype wire
